// ===== sv/mtb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_pkg
// Shared constants, codes and types of the median threshold bitmap block.
// ----------------------------------------------------------------------------
package mtb_pkg;

    // Histogram geometry and counter sizes.
    localparam int LEVELS     = 256;
    localparam int LEVEL_W    = $clog2(LEVELS);
    localparam int PIXEL_W    = 8;
    localparam int KIND_W     = 2;
    localparam int CNT_W      = 23;
    localparam int BAND_W     = LEVEL_W + 1;
    localparam logic [CNT_W-1:0]   MAX_PIXELS = CNT_W'(4194304);
    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(LEVELS - 1);

    // Depth of the command queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Item kinds as carried on the input tuser.
    localparam logic [KIND_W-1:0] KIND_ACCUM    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

    // Output beat packing.
    localparam int OUT_BITS = 2 * LEVEL_W + BAND_W + 3 + CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Command handed from the front part to the back part.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PIXEL_W-1:0] pixel;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic [CNT_W-1:0]   pixel_total;
        logic               frame_overflow;
        logic               excluded;
        logic               above_median;
        logic [BAND_W-1:0]  band_high;
        logic [LEVEL_W-1:0] band_low;
        logic [LEVEL_W-1:0] median_level;
    } t_result;

endpackage

// ===== sv/mtb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_front
// Input side: accepts beats, decodes the item kind and queues commands.
// ----------------------------------------------------------------------------
module mtb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [mtb_pkg::PIXEL_W-1:0]   i_s_tdata,
    input  logic [mtb_pkg::KIND_W-1:0]    i_s_tuser,
    output logic                          o_cmd_valid,
    output mtb_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_pop
);

    mtb_pkg::t_cmd                r_q [mtb_pkg::Q_DEPTH];
    logic [mtb_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [mtb_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [mtb_pkg::QCNT_W-1:0]   r_count;
    logic                         accept;
    logic                         push;
    logic                         pop;

    // The spare kind is taken from the bus but never reaches the back part.
    assign o_s_tready  = (r_count != mtb_pkg::QCNT_W'(mtb_pkg::Q_DEPTH));
    assign accept      = i_s_tvalid && o_s_tready;
    assign push        = accept && (i_s_tuser != mtb_pkg::KIND_SPARE);
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{kind: i_s_tuser, pixel: i_s_tdata};
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/mtb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_back
// Histogram memory, percentile scan, pixel classification and output register.
// ----------------------------------------------------------------------------
module mtb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  mtb_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_valid,
    output mtb_pkg::t_result  o_res,
    input  logic              i_res_ready
);

    localparam int CNT_W   = mtb_pkg::CNT_W;
    localparam int LEVEL_W = mtb_pkg::LEVEL_W;
    localparam int BAND_W  = mtb_pkg::BAND_W;
    localparam int PROD_W  = CNT_W + 3;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [LEVEL_W-1:0]  r_idx;

    // Histogram memory.
    logic [CNT_W-1:0]    r_mem [mtb_pkg::LEVELS];
    logic [CNT_W-1:0]    r_rd_data;
    logic [LEVEL_W-1:0]  rd_addr;
    logic [LEVEL_W-1:0]  wr_addr;
    logic [CNT_W-1:0]    wr_data;
    logic                wr_en;

    // Increment stage and last-write bypass.
    logic                r_b_valid;
    logic [LEVEL_W-1:0]  r_b_addr;
    logic                r_w_valid;
    logic [LEVEL_W-1:0]  r_w_addr;
    logic [CNT_W-1:0]    r_w_data;
    logic [CNT_W-1:0]    b_cur;
    logic [CNT_W-1:0]    b_inc;

    // Frame accounting.
    logic [CNT_W-1:0]    r_frame_count;
    logic                r_ovf_seen;
    logic [CNT_W-1:0]    r_last_total;
    logic                r_last_ovf;

    // Scan pipeline.
    logic                r_s1_v;
    logic [LEVEL_W-1:0]  r_s1_lvl;
    logic                r_s2_v;
    logic [LEVEL_W-1:0]  r_s2_lvl;
    logic [CNT_W-1:0]    r_run;
    logic                r_got_med;
    logic                r_got_low;
    logic [LEVEL_W-1:0]  r_med_c;
    logic [LEVEL_W-1:0]  r_low_c;
    logic [PROD_W-1:0]   run10;
    logic [PROD_W-1:0]   tot3;
    logic                hit_low;
    logic                hit_med;
    logic [LEVEL_W-1:0]  low_fix;

    // Stored levels and output register.
    logic [LEVEL_W-1:0]  r_med;
    logic [LEVEL_W-1:0]  r_low;
    logic [BAND_W-1:0]   r_high;
    logic                r_out_valid;
    mtb_pkg::t_result    r_out;

    logic                out_free;
    logic                pop;
    logic                pop_acc;
    logic                pop_close;
    logic                pop_cls;
    logic [LEVEL_W-1:0]  cls_pix;

    // Pop control: a classify item needs room in the output register.
    assign out_free  = !r_out_valid || i_res_ready;
    assign pop       = (r_state == ST_RUN) && i_cmd_valid &&
                       ((i_cmd.kind != mtb_pkg::KIND_CLASSIFY) || out_free);
    assign pop_acc   = pop && (i_cmd.kind == mtb_pkg::KIND_ACCUM);
    assign pop_close = pop && (i_cmd.kind == mtb_pkg::KIND_CLOSE);
    assign pop_cls   = pop && (i_cmd.kind == mtb_pkg::KIND_CLASSIFY);
    assign o_cmd_pop = pop;
    assign cls_pix   = i_cmd.pixel[LEVEL_W-1:0];

    // The bin just written is not yet visible on the read port, so bypass it.
    assign b_cur = (r_w_valid && (r_w_addr == r_b_addr)) ? r_w_data : r_rd_data;
    assign b_inc = b_cur + 1'b1;

    // Memory port selection: sweeps write zero behind the read.
    always_comb begin
        rd_addr = (r_state == ST_SCAN) ? r_idx : i_cmd.pixel[LEVEL_W-1:0];
        if ((r_state == ST_CLEAR) || (r_state == ST_SCAN)) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
            wr_data = '0;
        end else begin
            wr_en   = r_b_valid;
            wr_addr = r_b_addr;
            wr_data = b_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Exact percentile tests: 10*C >= 3*T and 2*C >= T.
    assign run10   = {r_run, 3'b000} + {2'b00, r_run, 1'b0};
    assign tot3    = {3'b000, r_last_total} + {2'b00, r_last_total, 1'b0};
    assign hit_low = (run10 >= tot3);
    assign hit_med = ({r_run, 1'b0} >= {1'b0, r_last_total});
    assign low_fix = (r_low_c > r_med_c) ? r_med_c : r_low_c;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_idx == mtb_pkg::LAST_LEVEL) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (pop_close) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_idx == mtb_pkg::LAST_LEVEL) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_s2_v && (r_s2_lvl == mtb_pkg::LAST_LEVEL)) n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Control and level registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_idx         <= '0;
            r_b_valid     <= 1'b0;
            r_w_valid     <= 1'b0;
            r_frame_count <= '0;
            r_ovf_seen    <= 1'b0;
            r_last_total  <= '0;
            r_last_ovf    <= 1'b0;
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
            r_run         <= '0;
            r_got_med     <= 1'b0;
            r_got_low     <= 1'b0;
            r_med         <= '0;
            r_low         <= '0;
            r_high        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_b_valid <= pop_acc && (r_frame_count < mtb_pkg::MAX_PIXELS);
            r_w_valid <= r_b_valid;
            r_s1_v    <= (r_state == ST_SCAN);
            r_s2_v    <= r_s1_v;

            // Sweep address for the clearing pass and the scan.
            if ((r_state == ST_CLEAR) || (r_state == ST_SCAN)) begin
                r_idx <= r_idx + 1'b1;
            end

            // Accumulate: count the pixel unless the frame is full.
            if (pop_acc) begin
                if (r_frame_count >= mtb_pkg::MAX_PIXELS) begin
                    r_ovf_seen <= 1'b1;
                end else begin
                    r_frame_count <= r_frame_count + 1'b1;
                end
            end

            // Close: freeze the frame totals and start a fresh frame.
            if (pop_close) begin
                r_last_total  <= r_frame_count;
                r_last_ovf    <= r_ovf_seen;
                r_frame_count <= '0;
                r_ovf_seen    <= 1'b0;
                r_run         <= '0;
                r_got_med     <= 1'b0;
                r_got_low     <= 1'b0;
            end

            // Running count over the bins.
            if (r_s1_v) begin
                r_run <= r_run + r_rd_data;
            end

            // First level that meets each test.
            if (r_s2_v) begin
                if (!r_got_low && hit_low) begin
                    r_got_low <= 1'b1;
                end
                if (!r_got_med && hit_med) begin
                    r_got_med <= 1'b1;
                end
            end

            // Commit the new levels.
            if (r_state == ST_FIN) begin
                r_med  <= r_med_c;
                r_low  <= low_fix;
                r_high <= {r_med_c, 1'b0} - {1'b0, low_fix};
            end

            // Output register handshake.
            if (pop_cls || ((r_state == ST_EMIT) && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (pop_acc) begin
            r_b_addr <= i_cmd.pixel[LEVEL_W-1:0];
        end
        if (r_b_valid) begin
            r_w_addr <= r_b_addr;
            r_w_data <= b_inc;
        end
        r_s1_lvl <= r_idx;
        r_s2_lvl <= r_s1_lvl;
        if (r_s2_v && !r_got_low && hit_low) begin
            r_low_c <= r_s2_lvl;
        end
        if (r_s2_v && !r_got_med && hit_med) begin
            r_med_c <= r_s2_lvl;
        end

        // Result beat for a classify item or at the end of a close.
        if (pop_cls) begin
            r_out.median_level   <= r_med;
            r_out.band_low       <= r_low;
            r_out.band_high      <= r_high;
            r_out.above_median   <= (cls_pix > r_med);
            r_out.excluded       <= (cls_pix >= r_low) && ({1'b0, cls_pix} <= r_high);
            r_out.frame_overflow <= r_last_ovf;
            r_out.pixel_total    <= r_last_total;
        end else if ((r_state == ST_EMIT) && out_free) begin
            r_out.median_level   <= r_med;
            r_out.band_low       <= r_low;
            r_out.band_high      <= r_high;
            r_out.above_median   <= 1'b0;
            r_out.excluded       <= 1'b0;
            r_out.frame_overflow <= r_last_ovf;
            r_out.pixel_total    <= r_last_total;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== sv/median_threshold_bitmap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_threshold_bitmap_core
// Median threshold bitmap with a 30th-percentile noise exclusion band.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry the item kind on s_axis_tuser (0 accumulate, 1 close,
//   2 classify, 3 ignored) and the grey pixel on s_axis_tdata. Accumulate
//   beats give no output; close and classify beats give one output beat each,
//   in input order.
//   Accumulate and classify items are taken at one per cycle while the back
//   part runs and, for classify, the output register has room. A classify
//   result passes through the queue and then the output register.
//   A close runs a scan of all 256 bins through the histogram memory read
//   port, one bin a cycle, and its result is presented after the scan, drain,
//   finish and emit states; items behind it wait in a four-entry queue,
//   after which s_axis_tready drops.
//   After reset the histogram is swept to zero; up to four items are queued
//   during the sweep. All levels and totals read zero until the first close.
//   When the receiver holds m_axis_tready low the result stays registered,
//   classify items stop and the queue fills, then the input stalls.
// ----------------------------------------------------------------------------
module median_threshold_bitmap_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,  // [7:0] pixel
    input  logic [1:0]                   i_s_axis_tuser,  // [1:0] kind
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [7:0] median_level, [15:8] band_low, [24:16] band_high,
    // [25] above_median, [26] excluded, [27] frame_overflow,
    // [50:28] pixel_total, [55:51] zero
    output logic [mtb_pkg::OUT_W-1:0]    o_m_axis_tdata
);

    logic              cmd_valid;
    logic              cmd_pop;
    mtb_pkg::t_cmd     cmd;
    mtb_pkg::t_result  res;

    // Front part: accept and queue.
    mtb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back part: histogram, scan and classification.
    mtb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    // Pack the result fields from the lowest bit up.
    assign o_m_axis_tdata = {{(mtb_pkg::OUT_W - mtb_pkg::OUT_BITS){1'b0}}, res};

endmodule

// ===== sv/mtb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtb_checker
// Port-level checks on the result stream of the bitmap core.
// ----------------------------------------------------------------------------
module mtb_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tvalid,
    input  logic                       i_tready,
    input  logic [mtb_pkg::OUT_W-1:0]  i_tdata
);

    logic [7:0]  median;
    logic [7:0]  low;
    logic [8:0]  high;
    logic        ovf;
    logic [22:0] total;

    assign median = i_tdata[7:0];
    assign low    = i_tdata[15:8];
    assign high   = i_tdata[24:16];
    assign ovf    = i_tdata[27];
    assign total  = i_tdata[50:28];

    // No result is offered straight out of reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_tvalid)
        else $error("result offered after reset");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && !i_tready |=> i_tvalid && $stable(i_tdata))
        else $error("result changed while stalled");

    // The band is symmetric about the median and starts at or below it.
    a_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid |-> (low <= median) &&
                     (high == ({1'b0, median, 1'b0} - {2'b00, low})))
        else $error("band bounds inconsistent with median");

    // The total never passes the frame limit, and overflow means it hit it.
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid |-> (total <= mtb_pkg::MAX_PIXELS) &&
                     (!ovf || (total == mtb_pkg::MAX_PIXELS)))
        else $error("pixel total inconsistent with overflow");

endmodule

bind median_threshold_bitmap_core mtb_checker u_mtb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (o_m_axis_tvalid),
    .i_tready (i_m_axis_tready),
    .i_tdata  (o_m_axis_tdata)
);

// ===== tb/median_threshold_bitmap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_threshold_bitmap_checker
// Watches both stream channels of the median threshold bitmap core, keeps a
// histogram of its own to predict each result beat, and compares every
// result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module median_threshold_bitmap_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [7:0]                i_s_tdata,   // [7:0] pixel
    input  logic [1:0]                i_s_tuser,   // [1:0] kind
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    // [7:0] median_level, [15:8] band_low, [24:16] band_high,
    // [25] above_median, [26] excluded, [27] frame_overflow,
    // [50:28] pixel_total, [55:51] zero
    input  logic [mtb_pkg::OUT_W-1:0] i_m_tdata,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_result_count
);

    // Predicted histogram and the levels of the last closed frame.
    logic [mtb_pkg::CNT_W-1:0]   hist [mtb_pkg::LEVELS];
    logic [mtb_pkg::CNT_W-1:0]   frame_pixels;
    logic                        overflow_now;
    logic [mtb_pkg::LEVEL_W-1:0] median_lvl;
    logic [mtb_pkg::LEVEL_W-1:0] band_lo;
    logic [mtb_pkg::BAND_W-1:0]  band_hi;
    logic [mtb_pkg::CNT_W-1:0]   closed_total;
    logic                        closed_overflow;

    // Result beats predicted but not yet seen, oldest first.
    mtb_pkg::t_result awaited_results[$];

    task automatic report_failure(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string field, input longint unsigned got,
                               input longint unsigned want);
        if (got !== want) begin
            report_failure($sformatf("result beat %0d, %s: got %0d, expected %0d",
                                     o_result_count, field, got, want));
        end
    endtask

    // Scan the bins upward: the 30th-percentile level is the first at which
    // ten times the running count reaches three times the total, the median
    // the first at which twice the running count reaches the total. The
    // scan empties the histogram and latches the frame total.
    function automatic void close_histogram();
        longint unsigned run_count;
        longint unsigned total;
        int              low;
        int              med;
        bit              got_low;
        bit              got_med;
        total     = frame_pixels;
        run_count = 0;
        low       = 0;
        med       = 0;
        got_low   = 1'b0;
        got_med   = 1'b0;
        for (int lv = 0; lv < mtb_pkg::LEVELS; lv++) begin
            run_count += hist[lv];
            if (!got_low && run_count * 10 >= total * 3) begin
                low     = lv;
                got_low = 1'b1;
            end
            if (!got_med && run_count * 2 >= total) begin
                med     = lv;
                got_med = 1'b1;
            end
            hist[lv] = '0;
        end
        if (low > med) low = med;
        median_lvl      = mtb_pkg::LEVEL_W'(med);
        band_lo         = mtb_pkg::LEVEL_W'(low);
        band_hi         = mtb_pkg::BAND_W'(2 * med - low);
        closed_total    = frame_pixels;
        closed_overflow = overflow_now;
        frame_pixels    = '0;
        overflow_now    = 1'b0;
    endfunction

    // Result beat for a close or a classify item, from the stored levels.
    function automatic mtb_pkg::t_result level_result(input logic [1:0] kind,
                                                      input logic [7:0] pixel);
        mtb_pkg::t_result r;
        r.median_level   = median_lvl;
        r.band_low       = band_lo;
        r.band_high      = band_hi;
        r.above_median   = (kind == mtb_pkg::KIND_CLASSIFY) && (pixel > median_lvl);
        r.excluded       = (kind == mtb_pkg::KIND_CLASSIFY) && (pixel >= band_lo)
                           && ({1'b0, pixel} <= band_hi);
        r.frame_overflow = closed_overflow;
        r.pixel_total    = closed_total;
        return r;
    endfunction

    always @(posedge i_clk) begin
        mtb_pkg::t_result got;
        mtb_pkg::t_result want;
        if (!i_rst_n) begin
            // Reset state: empty histogram, all levels zero.
            for (int lv = 0; lv < mtb_pkg::LEVELS; lv++) hist[lv] = '0;
            frame_pixels    = '0;
            overflow_now    = 1'b0;
            median_lvl      = '0;
            band_lo         = '0;
            band_hi         = '0;
            closed_total    = '0;
            closed_overflow = 1'b0;
            o_fail_count    = 0;
            o_result_count  = 0;
            awaited_results.delete();
        end else begin
            // Input beat: update the histogram or predict a result.
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    mtb_pkg::KIND_ACCUM: begin
                        if (frame_pixels >= mtb_pkg::MAX_PIXELS) begin
                            overflow_now = 1'b1;
                        end else begin
                            hist[i_s_tdata] = hist[i_s_tdata] + 1'b1;
                            frame_pixels    = frame_pixels + 1'b1;
                        end
                    end
                    mtb_pkg::KIND_CLOSE: begin
                        close_histogram();
                        awaited_results = {awaited_results,
                                           level_result(i_s_tuser, i_s_tdata)};
                    end
                    mtb_pkg::KIND_CLASSIFY: begin
                        awaited_results = {awaited_results,
                                           level_result(i_s_tuser, i_s_tdata)};
                    end
                    default: begin
                        // Spare kind: the block ignores it.
                    end
                endcase
            end

            // Result beat: compare with the oldest prediction.
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[mtb_pkg::OUT_BITS-1:0];
                if (awaited_results.size() == 0) begin
                    report_failure($sformatf("result beat %0d arrived with none awaited",
                                             o_result_count));
                end else begin
                    want = awaited_results.pop_front();
                    check_field("median_level", got.median_level, want.median_level);
                    check_field("band_low", got.band_low, want.band_low);
                    check_field("band_high", got.band_high, want.band_high);
                    check_field("above_median", got.above_median, want.above_median);
                    check_field("excluded", got.excluded, want.excluded);
                    check_field("frame_overflow", got.frame_overflow, want.frame_overflow);
                    check_field("pixel_total", got.pixel_total, want.pixel_total);
                    check_field("padding", i_m_tdata[mtb_pkg::OUT_W-1:mtb_pkg::OUT_BITS], 0);
                end
                o_result_count++;
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ===== tb/median_threshold_bitmap_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_threshold_bitmap_core_tb
// Drives directed and random pixel frames, close and classify beats into the
// median threshold bitmap core under varying flow control, and leaves the
// prediction and comparison of result beats to the checker.
// ----------------------------------------------------------------------------
module median_threshold_bitmap_core_tb;

    localparam int BEAT_TARGET    = 1050;
    localparam int SCAN_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                      clk     = 1'b0;
    logic                      rst_n   = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [7:0]                s_pixel = '0;
    logic [1:0]                s_kind  = mtb_pkg::KIND_ACCUM;
    logic                      m_valid;
    logic                      m_ready = 1'b1;
    logic [mtb_pkg::OUT_W-1:0] m_data;

    int fail_count;
    int pending;
    int result_count;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int beats_sent = 0;
    int idle_run   = 0;
    int kind_seen [4] = '{0, 0, 0, 0};

    // 8 ns clock.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    median_threshold_bitmap_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_pixel),
        .i_s_axis_tuser  (s_kind),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    median_threshold_bitmap_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_valid),
        .i_s_tready     (s_ready),
        .i_s_tdata      (s_pixel),
        .i_s_tuser      (s_kind),
        .i_m_tvalid     (m_valid),
        .i_m_tready     (m_ready),
        .i_m_tdata      (m_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        m_ready = ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles", idle_run);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one beat from a falling edge and return at the falling edge
    // after it has been taken, with random idle cycles ahead of it.
    task automatic send_beat(input logic [1:0] kind, input logic [7:0] pixel);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge clk);
        end
        s_valid = 1'b1;
        s_kind  = kind;
        s_pixel = pixel;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
        kind_seen[kind]++;
        beats_sent++;
    endtask

    // Hold the input quiet until every awaited result beat has come out.
    task automatic drain_results();
        s_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // A pixel spread around a centre level, clamped to the grey range.
    function automatic logic [7:0] pixel_near(input int centre, input int spread);
        int v;
        v = centre - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    initial begin
        int         phase;
        int         cur_phase;
        int         shape;
        int         centre;
        int         spread;
        int         roll;
        int         frame_len;
        int         long_frames;
        int         n_classify;
        logic [7:0] pix;

        cur_phase   = 0;
        long_frames = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Levels read zero before any frame is closed.
        send_beat(mtb_pkg::KIND_CLASSIFY, 8'd0);
        send_beat(mtb_pkg::KIND_CLASSIFY, 8'd255);
        send_beat(mtb_pkg::KIND_SPARE, 8'hAA);
        // Closing an empty frame, then a second close straight after it.
        send_beat(mtb_pkg::KIND_CLOSE, 8'd0);
        send_beat(mtb_pkg::KIND_CLOSE, 8'hFF);
        // Extreme pixels; both levels land on 128.
        send_beat(mtb_pkg::KIND_ACCUM, 8'd0);
        send_beat(mtb_pkg::KIND_ACCUM, 8'd255);
        send_beat(mtb_pkg::KIND_SPARE, 8'h55);
        send_beat(mtb_pkg::KIND_ACCUM, 8'd255);
        send_beat(mtb_pkg::KIND_ACCUM, 8'd128);
        send_beat(mtb_pkg::KIND_CLOSE, 8'h5A);
        send_beat(mtb_pkg::KIND_CLASSIFY, 8'd127);
        send_beat(mtb_pkg::KIND_CLASSIFY, 8'd128);
        send_beat(mtb_pkg::KIND_CLASSIFY, 8'd129);
        // Single-pixel frame.
        send_beat(mtb_pkg::KIND_ACCUM, 8'h55);
        send_beat(mtb_pkg::KIND_CLOSE, 8'd0);
        send_beat(mtb_pkg::KIND_CLASSIFY, 8'h55);
        send_beat(mtb_pkg::KIND_CLASSIFY, 8'h54);
        // Wide band whose upper bound passes the grey range.
        send_beat(mtb_pkg::KIND_ACCUM, 8'd10);
        send_beat(mtb_pkg::KIND_ACCUM, 8'd200);
        send_beat(mtb_pkg::KIND_ACCUM, 8'd200);
        send_beat(mtb_pkg::KIND_CLOSE, 8'd0);
        send_beat(mtb_pkg::KIND_CLASSIFY, 8'd255);
        send_beat(mtb_pkg::KIND_CLASSIFY, 8'd9);

        // Random frames, most of them closed, each followed by classify beats, with
        // some noise beats mixed in. Flow control changes in four phases.
        while (beats_sent < BEAT_TARGET) begin
            phase = beats_sent * 4 / BEAT_TARGET;
            if (phase > 3) phase = 3;
            if (phase != cur_phase) begin
                cur_phase = phase;
                drain_results();
                case (phase)
                    1:       begin idle_pct = 71; stall_pct = 0;  end
                    2:       begin idle_pct = 0;  stall_pct = 71; end
                    default: begin idle_pct = 33; stall_pct = 33; end
                endcase
            end

            shape  = $urandom_range(0, 3);
            centre = $urandom_range(0, 255);
            spread = $urandom_range(0, 40);
            roll   = $urandom_range(0, 99);
            if (roll < 4) begin
                frame_len = 0;
            end else if (roll < 7 && long_frames < 3) begin
                frame_len = $urandom_range(150, 300);
                long_frames++;
            end else begin
                frame_len = $urandom_range(1, 40);
            end

            for (int n = 0; n < frame_len; n++) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_beat($urandom_range(0, 1) ? mtb_pkg::KIND_SPARE
                                                   : mtb_pkg::KIND_CLASSIFY, 8'($urandom));
                end
                case (shape)
                    0:       pix = 8'($urandom);
                    1:       pix = pixel_near(centre, spread);
                    2:       pix = $urandom_range(0, 1) ? pixel_near(centre, 0)
                                                        : pixel_near(centre + 2 * spread, 0);
                    default: pix = $urandom_range(0, 1) ? 8'd0 : 8'd255;
                endcase
                send_beat(mtb_pkg::KIND_ACCUM, pix);
            end

            // Now and then a frame runs on into the next, or closes twice.
            if ($urandom_range(0, 19) != 0) send_beat(mtb_pkg::KIND_CLOSE, 8'($urandom));
            if ($urandom_range(0, 9) == 0) send_beat(mtb_pkg::KIND_CLOSE, 8'($urandom));

            // Classify mostly around the frame's levels.
            n_classify = $urandom_range(1, 8);
            for (int n = 0; n < n_classify; n++) begin
                send_beat(mtb_pkg::KIND_CLASSIFY,
                          ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                      : pixel_near(centre, spread + 8));
            end
        end

        // Let the last results out, then watch for stray beats.
        drain_results();
        repeat (SCAN_CYCLES) @(negedge clk);

        $display("Sent %0d accumulate, %0d close, %0d classify and %0d spare beats",
                 kind_seen[mtb_pkg::KIND_ACCUM], kind_seen[mtb_pkg::KIND_CLOSE],
                 kind_seen[mtb_pkg::KIND_CLASSIFY], kind_seen[mtb_pkg::KIND_SPARE]);
        $display("over four flow-control phases; %0d result beats checked, %0d mismatches.",
                 result_count, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
